>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable; clock and reset come from the user scope.
`define SCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sccb checker: property failed");

// Implication form: when ante holds, cons must hold on the same edge.
`define SCM_ASSERT_IMP(lbl, ante, cons) \
  `SCM_ASSERT(lbl, (ante) |-> (cons))

`endif

>>> sv/scm_pkg.sv
// Types and constants of the SCCB register master.
`default_nettype none

package scm_pkg;

  // Raw kind codes on the request stream
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_TICKS_PER_DELAY = 2'd1;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_WRITE,
    REQ_READ
  } req_kind_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_HI,
    PH_ST_LO,
    PH_WB_LO,
    PH_WB_HI,
    PH_AK_LO,
    PH_AK_HI,
    PH_RB_LO,
    PH_RB_HI,
    PH_NK_LO,
    PH_NK_HI,
    PH_SP_A,
    PH_SP_B,
    PH_SP_C
  } phase_e;

  // Classified request as held in the queue
  typedef struct packed {
    req_kind_e   kind;
    logic [7:0]  reg_addr;
    logic [7:0]  wr_val;
    logic        sda;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // One result
  typedef struct packed {
    logic [7:0] rd_byte;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } result_t;

  // Byte sent in position idx of the transaction
  function automatic logic [7:0] byte_for(input logic [6:0] dev,
                                          input logic [1:0] idx,
                                          input logic       is_rd,
                                          input logic [7:0] reg_addr,
                                          input logic [7:0] wr_val);
    logic [7:0] a;
    a = {dev, 1'b0};
    if (idx == 2'd0) begin
      byte_for = a;
    end else if (idx == 2'd1) begin
      byte_for = reg_addr;
    end else if (is_rd) begin
      byte_for = {dev, 1'b1};
    end else begin
      byte_for = wr_val;
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/sccb_register_master.sv
// Top level of the SCCB register master.
// Usage:
//  - Request stream (s_axis_*): one request per bus delay tick. tuser carries
//    the kind (0 plain tick, 1 register write, 2 register read, 3 acts as a
//    plain tick); tdata carries register address, write value and the sampled
//    SDA pin level. A write or read request starts a transaction only when
//    the sequencer is idle; otherwise it counts as a plain tick.
//  - Result stream (m_axis_*): exactly one result per request, in order:
//    SCL and SDA release levels for this tick, busy, done and the read byte
//    (nonzero only on the done tick of a read).
//  - Config channel: index 0 device address (7 bits), index 1 ticks per
//    delay phase (0 acts as 1). Always ready; write only while idle.
// An accepted request passes through the queue into the result register.
// While the receiver is ready, one request per cycle is sustained and the
// sequencer advances one tick per cycle; the result register is single-entry.
// A two-entry queue separates intake from the sequencer, so a stalled
// receiver backs up into the queue and then drops s_axis_tready.
// Reset: sequencer idle, both lines released, device address 0x21, one tick
// per phase, queue and result register empty.
`default_nettype none

module sccb_register_master import scm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [7:0] register_address, [15:8] write_value,
                                          // [16] sda_sample, [23:17] zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [0] clock_released, [1] data_released,
                                          // [2] busy_res, [3] done_res,
                                          // [11:4] read_byte, [15:12] zero
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  head_t   head;
  logic    pop;
  result_t res;

  assign cfg_ready_o = 1'b1;

  // Intake and classification
  scm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_reg_i   (s_axis_tdata[7:0]),
    .in_val_i   (s_axis_tdata[15:8]),
    .in_sda_i   (s_axis_tdata[16]),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Bus sequencer with result register
  scm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {4'd0, res.rd_byte, res.done, res.busy, res.sda, res.scl};

endmodule

`default_nettype wire

>>> sv/scm_front.sv
// Front end: request classification and a two-entry queue.
`default_nettype none

module scm_front import scm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  in_kind_i,
  input  wire logic [7:0]  in_reg_i,
  input  wire logic [7:0]  in_val_i,
  input  wire logic        in_sda_i,
  output head_t            head_o,
  input  wire logic        pop_i
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.reg_addr = in_reg_i;
    cls.wr_val   = in_val_i;
    cls.sda      = in_sda_i;
    unique case (in_kind_i)
      KIND_WRITE: cls.kind = REQ_WRITE;
      KIND_READ:  cls.kind = REQ_READ;
      default:    cls.kind = REQ_TICK;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

>>> sv/scm_back.sv
// Back end: bus phase sequencer, configuration registers and result register.
`default_nettype none

module scm_back import scm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire head_t       head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output result_t          out_o
);

  logic [6:0] dev_q;
  logic [7:0] tpd_q;

  phase_e     phase_q, phase_d;
  logic [2:0] bc_q, bc_d;
  logic [1:0] bi_q, bi_d;
  logic [7:0] tx_q, tx_d, rx_q, rx_d;
  logic       rdf_q, rdf_d;
  logic [7:0] reg_q, reg_d, val_q, val_d;
  logic [7:0] dc_q, dc_d;

  logic       take, start, done;
  phase_e     ph;
  logic [7:0] dly, dc_inc;
  logic       scl, sda;
  result_t    res_q;
  logic       ovalid_q;
  item_t      it;

  assign it    = head_i.item;
  assign take  = head_i.valid && (!ovalid_q || out_ready_i);
  assign pop_o = take;
  assign start = (phase_q == PH_IDLE) && (it.kind != REQ_TICK);
  assign dly   = (tpd_q == 8'd0) ? 8'd1 : tpd_q;

  // Next state
  always_comb begin
    ph    = start ? PH_ST_HI : phase_q;
    rdf_d = start ? (it.kind == REQ_READ) : rdf_q;
    reg_d = start ? it.reg_addr : reg_q;
    val_d = (start && it.kind == REQ_WRITE) ? it.wr_val : val_q;
    bi_d  = start ? 2'd0 : bi_q;
    bc_d  = start ? 3'd0 : bc_q;
    dc_d  = start ? 8'd0 : dc_q;
    tx_d  = tx_q;
    rx_d  = rx_q;
    phase_d = ph;
    done  = 1'b0;
    dc_inc = dc_d + 8'd1;
    if (ph != PH_IDLE) begin
      if (dc_inc >= dly) begin
        dc_d = 8'd0;
        unique case (ph)
          PH_ST_HI: phase_d = PH_ST_LO;
          PH_ST_LO: begin
            tx_d    = byte_for(dev_q, bi_d, rdf_d, reg_d, val_d);
            bc_d    = 3'd0;
            phase_d = PH_WB_LO;
          end
          PH_WB_LO: phase_d = PH_WB_HI;
          PH_WB_HI: begin
            if (bc_d == 3'd7) begin
              phase_d = PH_AK_LO;
            end else begin
              tx_d    = {tx_q[6:0], 1'b0};
              bc_d    = bc_d + 3'd1;
              phase_d = PH_WB_LO;
            end
          end
          PH_AK_LO: phase_d = PH_AK_HI;
          PH_AK_HI: begin
            bi_d = bi_d + 2'd1;
            bc_d = 3'd0;
            if (!rdf_d && bi_d == 2'd3) begin
              phase_d = PH_SP_A;
            end else if (rdf_d && bi_d == 2'd2) begin
              phase_d = PH_ST_HI;
            end else if (rdf_d && bi_d == 2'd3) begin
              rx_d    = 8'd0;
              phase_d = PH_RB_LO;
            end else begin
              tx_d    = byte_for(dev_q, bi_d, rdf_d, reg_d, val_d);
              phase_d = PH_WB_LO;
            end
          end
          PH_RB_LO: phase_d = PH_RB_HI;
          PH_RB_HI: begin
            rx_d = {rx_q[6:0], it.sda};
            if (bc_d == 3'd7) begin
              phase_d = PH_NK_LO;
            end else begin
              bc_d    = bc_d + 3'd1;
              phase_d = PH_RB_LO;
            end
          end
          PH_NK_LO: phase_d = PH_NK_HI;
          PH_NK_HI: phase_d = PH_SP_A;
          PH_SP_A:  phase_d = PH_SP_B;
          PH_SP_B:  phase_d = PH_SP_C;
          PH_SP_C: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          default:  phase_d = PH_IDLE;
        endcase
      end else begin
        dc_d = dc_inc;
      end
    end
  end

  // Line levels for the phase active on this tick
  always_comb begin
    unique case (ph)
      PH_ST_LO: begin scl = 1'b1; sda = 1'b0;    end
      PH_WB_LO: begin scl = 1'b0; sda = tx_q[7]; end
      PH_WB_HI: begin scl = 1'b1; sda = tx_q[7]; end
      PH_AK_LO, PH_RB_LO, PH_NK_LO: begin scl = 1'b0; sda = 1'b1; end
      PH_SP_A:  begin scl = 1'b0; sda = 1'b0;    end
      PH_SP_B:  begin scl = 1'b1; sda = 1'b0;    end
      default:  begin scl = 1'b1; sda = 1'b1;    end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= 7'h21;
      tpd_q   <= 8'd1;
      phase_q <= PH_IDLE;
      bc_q    <= 3'd0;
      bi_q    <= 2'd0;
      tx_q    <= 8'd0;
      rx_q    <= 8'd0;
      rdf_q   <= 1'b0;
      reg_q   <= 8'd0;
      val_q   <= 8'd0;
      dc_q    <= 8'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DEVICE_ADDRESS:  dev_q <= cfg_data_i[6:0];
          REG_TICKS_PER_DELAY: tpd_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (take) begin
        phase_q <= phase_d;
        bc_q    <= bc_d;
        bi_q    <= bi_d;
        tx_q    <= tx_d;
        rx_q    <= rx_d;
        rdf_q   <= rdf_d;
        reg_q   <= reg_d;
        val_q   <= val_d;
        dc_q    <= dc_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.scl     <= (ph == PH_IDLE) ? 1'b1 : scl;
      res_q.sda     <= (ph == PH_IDLE) ? 1'b1 : sda;
      res_q.busy    <= (phase_d != PH_IDLE);
      res_q.done    <= done;
      res_q.rd_byte <= (done && rdf_d) ? rx_q : 8'd0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

>>> sv/scm_checker.sv
// Port-level checker for the SCCB register master, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module scm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A stalled result holds
  `SCM_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
  // Read byte shows only on a done tick
  `SCM_ASSERT_IMP(a_rd_only_done, m_axis_tvalid && !m_axis_tdata[3], m_axis_tdata[11:4] == 8'd0)
  // Done ends the transaction
  `SCM_ASSERT_IMP(a_done_not_busy, m_axis_tvalid && m_axis_tdata[3], !m_axis_tdata[2])
  // Off the bus both lines are released
  `SCM_ASSERT_IMP(a_idle_released, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[1:0] == 2'b11)

endmodule

bind sccb_register_master scm_checker u_scm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
